// ===== hw/rtl/sct_pkg.sv =====
// ----------------------------------------------------------------------------
// sct_pkg: source code tokenizer package
// token kind codes, scan modes and character class helpers
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned KindW  = 6;
  localparam int unsigned LenW   = 16;
  localparam int unsigned ValueW = 64;
  localparam int unsigned StartW = 32;

  typedef enum logic [KindW-1:0] {
    TK_ILLEGAL = 6'd0, TK_EOF = 6'd1, TK_IDENT = 6'd2, TK_INTEGER = 6'd3,
    TK_STRING = 6'd4, TK_BOOL = 6'd5, TK_EQUAL = 6'd6, TK_ASSIGN = 6'd7,
    TK_AND = 6'd8, TK_OR = 6'd9, TK_INCREMENT = 6'd10, TK_PLUS_ASSIGN = 6'd11,
    TK_PLUS = 6'd12, TK_DECREMENT = 6'd13, TK_MINUS_ASSIGN = 6'd14,
    TK_MINUS = 6'd15, TK_NOT_EQUAL = 6'd16, TK_EXCLAMATION = 6'd17,
    TK_ASTERISK_ASSIGN = 6'd18, TK_ASTERISK = 6'd19, TK_SLASH_ASSIGN = 6'd20,
    TK_SLASH = 6'd21, TK_COMMA = 6'd22, TK_SEMICOLON = 6'd23,
    TK_COLON_ASSIGN = 6'd24, TK_COLON = 6'd25, TK_LESS_EQUAL = 6'd26,
    TK_LESS = 6'd27, TK_GREATER_EQUAL = 6'd28, TK_GREATER = 6'd29,
    TK_LPAREN = 6'd30, TK_RPAREN = 6'd31, TK_LBRACE = 6'd32, TK_RBRACE = 6'd33,
    TK_LET = 6'd34, TK_INT = 6'd35, TK_RETURN = 6'd36, TK_VOID = 6'd37,
    TK_FOR = 6'd38, TK_IF = 6'd39, TK_ELSE = 6'd40, TK_RANGE = 6'd41,
    TK_STR = 6'd42
  } token_kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_OP     = 5'b00010,
    MODE_IDENT  = 5'b00100,
    MODE_NUMBER = 5'b01000,
    MODE_STRING = 5'b10000
  } scan_mode_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [StartW-1:0] start;
    logic [LenW-1:0]   length;
    logic [ValueW-1:0] value;
  } token_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  // operator that may take a second character; illegal for lone & and |
  function automatic logic is_lone_op(input logic [7:0] c);
    case (c)
      "=", "+", "-", "!", "*", "/", ":", "<", ">", "&", "|": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic token_kind_e lone_kind(input logic [7:0] c);
    case (c)
      "=":     return TK_ASSIGN;
      "+":     return TK_PLUS;
      "-":     return TK_MINUS;
      "!":     return TK_EXCLAMATION;
      "*":     return TK_ASTERISK;
      "/":     return TK_SLASH;
      ":":     return TK_COLON;
      "<":     return TK_LESS;
      ">":     return TK_GREATER;
      default: return TK_ILLEGAL;
    endcase
  endfunction

  // pair match flag in bit 6, kind below
  function automatic logic [KindW:0] pair_kind(input logic [7:0] a,
                                               input logic [7:0] b);
    logic eq;
    eq = (b == "=");
    case (a)
      "=": return {eq, TK_EQUAL};
      "&": return {b == "&", TK_AND};
      "|": return {b == "|", TK_OR};
      "+": return (b == "+") ? {1'b1, TK_INCREMENT} : {eq, TK_PLUS_ASSIGN};
      "-": return (b == "-") ? {1'b1, TK_DECREMENT} : {eq, TK_MINUS_ASSIGN};
      "!": return {eq, TK_NOT_EQUAL};
      "*": return {eq, TK_ASTERISK_ASSIGN};
      "/": return {eq, TK_SLASH_ASSIGN};
      ":": return {eq, TK_COLON_ASSIGN};
      "<": return {eq, TK_LESS_EQUAL};
      ">": return {eq, TK_GREATER_EQUAL};
      default: return {1'b0, TK_ILLEGAL};
    endcase
  endfunction

  // single character tokens, match flag in bit 6
  function automatic logic [KindW:0] single_kind(input logic [7:0] c);
    case (c)
      ",":     return {1'b1, TK_COMMA};
      ";":     return {1'b1, TK_SEMICOLON};
      "(":     return {1'b1, TK_LPAREN};
      ")":     return {1'b1, TK_RPAREN};
      "{":     return {1'b1, TK_LBRACE};
      "}":     return {1'b1, TK_RBRACE};
      default: return {1'b0, TK_ILLEGAL};
    endcase
  endfunction

  // keyword lookup on first six characters, zero padded; kind in [5:0],
  // boolean value in bit 6
  function automatic logic [KindW:0] keyword_kind(input logic [47:0] w,
                                                  input logic [LenW-1:0] len);
    case ({len, w})
      {16'd3, 48'h6c6574000000}: return {1'b0, TK_LET};
      {16'd3, 48'h696e74000000}: return {1'b0, TK_INT};
      {16'd6, 48'h72657475726e}: return {1'b0, TK_RETURN};
      {16'd4, 48'h766f69640000}: return {1'b0, TK_VOID};
      {16'd3, 48'h666f72000000}: return {1'b0, TK_FOR};
      {16'd4, 48'h747275650000}: return {1'b1, TK_BOOL};
      {16'd5, 48'h66616c736500}: return {1'b0, TK_BOOL};
      {16'd2, 48'h696600000000}: return {1'b0, TK_IF};
      {16'd4, 48'h656c73650000}: return {1'b0, TK_ELSE};
      {16'd5, 48'h72616e676500}: return {1'b0, TK_RANGE};
      {16'd3, 48'h737472000000}: return {1'b0, TK_STR};
      default:                   return {1'b0, TK_IDENT};
    endcase
  endfunction

endpackage

// ===== hw/rtl/source_code_tokenizer.sv =====
// ----------------------------------------------------------------------------
// source_code_tokenizer: streaming lexer
// one character per word in, tokens out with start, length and value
// ----------------------------------------------------------------------------
// output: the first token from a character is registered and shown the cycle after the character is taken
// throughput: one character per cycle while tokens are taken; a character giving two tokens
//   holds the input while the second token waits in slot 1
// reset: asynchronous, clears scan state, position and output valids
module source_code_tokenizer
  import sct_pkg::*;
#(
  parameter int unsigned KEYWORD_CHARS = 6,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     char_in_valid_i,
  output logic                     char_in_ready_o,
  input  logic [7:0]               char_in_i,
  output logic                     token_valid_o,
  input  logic                     token_ready_i,
  output logic [KindW-1:0]         token_kind_o,
  output logic [StartW-1:0]        token_start_o,
  output logic [LenW-1:0]          token_length_o,
  output logic signed [ValueW-1:0] token_value_o,
  output logic                     last_of_item_o
);

  localparam int unsigned KbW = 8 * KEYWORD_CHARS;
  localparam logic [LenW-1:0] LenMax = '1;

  // scan state
  scan_mode_e             mode_q, mode_d;
  logic [7:0]             pend_q, pend_d;
  logic [KbW-1:0]         kbuf_q, kbuf_d;    // char 0 in top byte
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LenW-1:0]        run_q, run_d;
  logic [ValueW-1:0]      acc_q, acc_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  // output slots: slot 0 shown on the port, slot 1 queued second token
  logic   out0_vld_q, out1_vld_q;
  token_t out0_q, out1_q;
  logic   out0_last_q;

  logic   accept;
  logic   n_tok0, n_tok1;
  token_t tok0, tok1;
  logic   drain;

  // output fifo of two: take new word when slot 1 empty and slot 0 leaves
  // or is empty; a pair only when both slots free up
  assign drain = token_ready_i & out0_vld_q;
  assign char_in_ready_o = !out1_vld_q && (!out0_vld_q || token_ready_i);
  assign accept = char_in_valid_i & char_in_ready_o;

  function automatic logic [StartW-1:0] to_start(input logic [OFFSET_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[StartW-1:0];
  endfunction

  // keyword compare uses first six chars only; longer buffers never match
  function automatic logic [47:0] kw_window(input logic [KbW-1:0] b);
    return b[KbW-1 -: 48];
  endfunction

  always_comb begin
    logic       used;
    logic [6:0] pk;
    logic [6:0] sk;
    logic [6:0] kk;
    logic [7:0] c;
    logic [OFFSET_BITS-1:0] p;
    logic       tokx;
    token_t     t;
    c = char_in_i;
    p = pos_q;
    used = 1'b0;
    mode_d = mode_q; pend_d = pend_q; kbuf_d = kbuf_q; start_d = start_q;
    run_d = run_q; acc_d = acc_q; pos_d = pos_q;
    tokx = 1'b0;
    t = '0;
    n_tok0 = 1'b0; n_tok1 = 1'b0; tok0 = '0; tok1 = '0;
    pk = pair_kind(pend_q, c);
    kk = keyword_kind(kw_window(kbuf_q), run_q);
    sk = single_kind(c);

    unique case (mode_q)
      MODE_OP: begin
        tokx = 1'b1;
        t.start = to_start(start_q);
        if (pk[6]) begin
          t.kind = pk[5:0]; t.length = 16'd2; used = 1'b1;
        end else begin
          t.kind = lone_kind(pend_q); t.length = 16'd1;
          t.value = (lone_kind(pend_q) == TK_ILLEGAL) ? 64'(pend_q) : '0;
        end
        mode_d = MODE_IDLE;
      end
      MODE_IDENT: begin
        if (is_letter(c)) begin
          if (run_q < LenW'(KEYWORD_CHARS))
            kbuf_d[KbW-1-8*run_q[7:0] -: 8] = c;
          if (run_q != LenMax) run_d = run_q + 1'b1;
          used = 1'b1;
        end else begin
          tokx = 1'b1;
          t.kind = kk[5:0]; t.start = to_start(start_q); t.length = run_q;
          t.value = 64'(kk[6]);
          if (run_q > 16'd6) t = '{TK_IDENT, to_start(start_q), run_q, '0};
          mode_d = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + 64'(c - 8'h30);
          if (run_q != LenMax) run_d = run_q + 1'b1;
          used = 1'b1;
        end else begin
          tokx = 1'b1;
          t = '{TK_INTEGER, to_start(start_q), run_q, acc_q};
          mode_d = MODE_IDLE;
        end
      end
      MODE_STRING: begin
        if (c == 8'h22 || c == 8'h00) begin
          tokx = 1'b1;
          t = '{TK_STRING, to_start(start_q), run_q, '0};
          mode_d = MODE_IDLE;
          used = (c == 8'h22);
        end else begin
          if (run_q != LenMax) run_d = run_q + 1'b1;
          used = 1'b1;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase

    n_tok0 = tokx; tok0 = t;

    if (!used) begin
      t = '0;
      tokx = 1'b0;
      if (c == 8'h00) begin
        tokx = 1'b1;
        t = '{TK_EOF, to_start(p), '0, '0};
      end else if (is_space(c)) begin
        tokx = 1'b0;
      end else if (is_lone_op(c)) begin
        mode_d = MODE_OP; pend_d = c; start_d = p;
      end else if (sk[6]) begin
        tokx = 1'b1; t = '{sk[5:0], to_start(p), 16'd1, '0};
      end else if (c == 8'h22) begin
        mode_d = MODE_STRING; start_d = p + 1'b1; run_d = '0;
      end else if (is_letter(c)) begin
        mode_d = MODE_IDENT;
        kbuf_d = '0; kbuf_d[KbW-1 -: 8] = c;
        run_d = 16'd1; start_d = p;
      end else if (is_digit(c)) begin
        mode_d = MODE_NUMBER; acc_d = 64'(c - 8'h30); run_d = 16'd1; start_d = p;
      end else begin
        tokx = 1'b1; t = '{TK_ILLEGAL, to_start(p), 16'd1, 64'(c)};
      end
      // second token goes behind the first
      if (tokx) begin
        if (n_tok0) begin
          n_tok1 = 1'b1; tok1 = t;
        end else begin
          n_tok0 = 1'b1; tok0 = t;
        end
      end
    end

    pos_d = p + 1'b1;
    // end of text: full scanner reset
    if (c == 8'h00) begin
      mode_d = MODE_IDLE; pend_d = '0; kbuf_d = '0; start_d = '0;
      run_d = '0; acc_d = '0; pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pend_q  <= '0;
      kbuf_q  <= '0;
      start_q <= '0;
      run_q   <= '0;
      acc_q   <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      kbuf_q  <= kbuf_d;
      start_q <= start_d;
      run_q   <= run_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
    end
  end

  // output slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out0_vld_q  <= 1'b0;
      out1_vld_q  <= 1'b0;
      out0_last_q <= 1'b0;
    end else begin
      if (accept && n_tok0) begin
        out0_vld_q  <= 1'b1;
        out0_last_q <= !n_tok1;
        out1_vld_q  <= n_tok1;
      end else if (out1_vld_q && drain) begin
        out0_vld_q  <= 1'b1;
        out0_last_q <= 1'b1;
        out1_vld_q  <= 1'b0;
      end else if (drain) begin
        out0_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && n_tok0) begin
      out0_q <= tok0;
      out1_q <= tok1;
    end else if (out1_vld_q && drain) begin
      out0_q <= out1_q;
    end
  end

  assign token_valid_o  = out0_vld_q;
  assign token_kind_o   = out0_q.kind;
  assign token_start_o  = out0_q.start;
  assign token_length_o = out0_q.length;
  assign token_value_o  = out0_q.value;
  assign last_of_item_o = out0_last_q;

endmodule

// ===== hw/rtl/sct_checker.sv =====
// ----------------------------------------------------------------------------
// sct_checker: port level checks for the tokenizer
// handshake and token sanity seen from the ports
// ----------------------------------------------------------------------------
module sct_checker
  import sct_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              char_in_valid_i,
  input logic              char_in_ready_o,
  input logic [7:0]        char_in_i,
  input logic              token_valid_o,
  input logic              token_ready_i,
  input logic [KindW-1:0]  token_kind_o,
  input logic [LenW-1:0]   token_length_o,
  input logic              last_of_item_o
);

  // a stalled token holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o && !token_ready_i |=> token_valid_o && $stable(token_kind_o))
    else $error("token changed while stalled");

  // eof is always the last token of its word and has zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o && token_kind_o == TK_EOF |-> last_of_item_o && token_length_o == '0)
    else $error("bad eof token");

  // accepted end of text gives a token next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_in_valid_i && char_in_ready_o && char_in_i == 8'h00 |=> token_valid_o)
    else $error("no token after end of text");

  // kind codes stay in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    token_valid_o |-> token_kind_o <= TK_STR)
    else $error("kind out of range");

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (
  .clk_i, .rst_ni, .char_in_valid_i, .char_in_ready_o, .char_in_i,
  .token_valid_o, .token_ready_i, .token_kind_o, .token_length_o,
  .last_of_item_o
);
